FILE: hdl/spms_pkg.sv
// Shared widths, constants and reset values of the stroke match scorer.
`timescale 1ns / 1ps
package spms_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 34;
  localparam int SUM_W = 35;
  localparam int RAD_W = 34;
  localparam int ROOT_W = 17;
  localparam int SREM_W = 20;
  localparam int NUM_W = 46;
  localparam int DEN_W = 33;
  localparam int DREM_W = 34;
  localparam int QUO_W = 17;
  localparam int DIST_W = 24;
  localparam int DIR_W = 23;
  localparam int SCORE_W = 17;
  localparam int IT_W = 6;
  localparam int ST_W = 5;

  localparam logic [IT_W-1:0] SQRT_STEPS = 6'd17;
  localparam logic [IT_W-1:0] DIV_STEPS = 6'd46;

  localparam logic [SCORE_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [SCORE_W-1:0] HALF_Q16 = 17'd32768;
  localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [DIR_W-1:0] DIR_MAX = 23'h7FFFFF;
  localparam logic [COORD_W-1:0] TOL_RESET = 16'd2048;

  localparam int DEF_MAX_POINTS = 64;

endpackage

FILE: hdl/stroke_path_match_score.sv
// Stroke match scorer: bit-serial square roots and divisions over a shared datapath.
// Each point within MAX_POINTS runs one square root for its distance; a point with a valid
// segment adds two more roots, one division and the scaling steps; a last point adds one or
// two final divisions, none under two points.
// Throughput: one point at a time; the next point is taken once the previous one is done.
// Reset (rst_n low, synchronous) clears the accumulators and result valid, tolerance 2048.
`timescale 1ns / 1ps
module stroke_path_match_score import spms_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COORD_W-1:0]   in_user_x,
  input  logic signed [COORD_W-1:0]   in_user_y,
  input  logic signed [COORD_W-1:0]   in_ref_x,
  input  logic signed [COORD_W-1:0]   in_ref_y,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [SCORE_W-1:0]          out_score,
  output logic [SCORE_W-1:0]          out_spatial_part,
  output logic [SCORE_W-1:0]          out_direction_part,
  output logic                        out_too_long,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [COORD_W-1:0]          cfg_tolerance
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  localparam logic [ST_W-1:0] ST_IDLE   = 5'd0;
  localparam logic [ST_W-1:0] ST_D_MX   = 5'd1;
  localparam logic [ST_W-1:0] ST_D_MY   = 5'd2;
  localparam logic [ST_W-1:0] ST_D_RT   = 5'd3;
  localparam logic [ST_W-1:0] ST_SQRT   = 5'd4;
  localparam logic [ST_W-1:0] ST_D_ACC  = 5'd5;
  localparam logic [ST_W-1:0] ST_SEG    = 5'd6;
  localparam logic [ST_W-1:0] ST_SCALE  = 5'd7;
  localparam logic [ST_W-1:0] ST_U_MX   = 5'd8;
  localparam logic [ST_W-1:0] ST_U_MY   = 5'd9;
  localparam logic [ST_W-1:0] ST_U_RT   = 5'd10;
  localparam logic [ST_W-1:0] ST_R_MX   = 5'd11;
  localparam logic [ST_W-1:0] ST_R_MY   = 5'd12;
  localparam logic [ST_W-1:0] ST_R_RT   = 5'd13;
  localparam logic [ST_W-1:0] ST_P_MX   = 5'd14;
  localparam logic [ST_W-1:0] ST_P_MY   = 5'd15;
  localparam logic [ST_W-1:0] ST_P_LEN  = 5'd16;
  localparam logic [ST_W-1:0] ST_P_DV   = 5'd17;
  localparam logic [ST_W-1:0] ST_DIV    = 5'd18;
  localparam logic [ST_W-1:0] ST_P_ACC  = 5'd19;
  localparam logic [ST_W-1:0] ST_PT     = 5'd20;
  localparam logic [ST_W-1:0] ST_F_MUL  = 5'd21;
  localparam logic [ST_W-1:0] ST_F_DV   = 5'd22;
  localparam logic [ST_W-1:0] ST_F_SP   = 5'd23;
  localparam logic [ST_W-1:0] ST_F_DIR  = 5'd24;
  localparam logic [ST_W-1:0] ST_EMIT   = 5'd25;

  // Vector slots for the segment similarity: user x, user y, reference x, reference y.
  localparam int VUX = 0;
  localparam int VUY = 1;
  localparam int VRX = 2;
  localparam int VRY = 3;

  function automatic logic [2*DIFF_W:0] scale_step(input logic [DIFF_W-1:0] mx,
                                                   input logic [DIFF_W-1:0] my);
    logic [DIFF_W-1:0] m;
    logic [2*DIFF_W:0] res;
    m = (mx > my) ? mx : my;
    if (m[DIFF_W-1:DIFF_W-2] != 2'b00) begin
      res = {1'b0, mx >> 1, my >> 1};
    end else if (m[DIFF_W-2:DIFF_W-3] == 2'b00) begin
      res = {1'b0, mx << 1, my << 1};
    end else begin
      res = {1'b1, mx, my};
    end
    return res;
  endfunction

  function automatic logic signed [DIFF_W-1:0] to_signed(input logic sgn,
                                                         input logic [DIFF_W-1:0] mag);
    logic signed [DIFF_W-1:0] v;
    v = $signed(mag);
    return sgn ? -v : v;
  endfunction

  logic [ST_W-1:0]           state_r, state_nxt, ret_r, ret_nxt;
  logic [COORD_W-1:0]        tol_r, tol_nxt;
  logic [COORD_W-1:0]        ux_r, ux_nxt, uy_r, uy_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic                      last_r, last_nxt;
  logic [COORD_W-1:0]        pux_r, pux_nxt, puy_r, puy_nxt, prx_r, prx_nxt, pry_r, pry_nxt;
  logic [DIST_W-1:0]         dist_sum_r, dist_sum_nxt;
  logic [DIR_W-1:0]          dir_sum_r, dir_sum_nxt;
  logic [CW-1:0]             vseg_cnt_r, vseg_cnt_nxt, pt_cnt_r, pt_cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [3:0]                sgn_r, sgn_nxt;
  logic [3:0][DIFF_W-1:0]    mag_r, mag_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt, dot_r, dot_nxt;
  logic [ROOT_W-2:0]         lu_r, lu_nxt, lr_r, lr_nxt;
  logic [RAD_W-1:0]          rad_r, rad_nxt;
  logic [SREM_W-1:0]         srem_r, srem_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [NUM_W-1:0]          num_r, num_nxt;
  logic [DEN_W-1:0]          den_r, den_nxt;
  logic [DREM_W-1:0]         drem_r, drem_nxt;
  logic [QUO_W-1:0]          quo_r, quo_nxt;
  logic                      qovf_r, qovf_nxt;
  logic [IT_W-1:0]           it_r, it_nxt;
  logic [SCORE_W-1:0]        spat_r, spat_nxt, dirp_r, dirp_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0]        out_score_r, out_score_nxt, out_spat_r, out_spat_nxt;
  logic [SCORE_W-1:0]        out_dir_r, out_dir_nxt;
  logic                      out_tl_r, out_tl_nxt;

  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [DIFF_W-1:0]  raw [4];
  logic signed [SUM_W-1:0]   sum_all;
  logic [SREM_W-1:0]         s_sh, s_trial;
  logic [DREM_W-1:0]         d_sh, d_den;
  logic                      d_ge;
  logic [2*DIFF_W:0]         sc_u, sc_r;
  logic [SUM_W-1:0]          dot_mag;
  logic [QUO_W-1:0]          t_lim, sim;
  logic [DIR_W:0]            dir_add;
  logic [DIST_W:0]           dist_add;
  logic [QUO_W:0]            loss;
  logic [SCORE_W:0]          score_sum;
  logic                      nz_u, nz_r;
  logic                      out_take;

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign out_take = out_valid_r && !out_stall;

  assign dx = $signed({ux_r[COORD_W-1], ux_r}) - $signed({rx_r[COORD_W-1], rx_r});
  assign dy = $signed({uy_r[COORD_W-1], uy_r}) - $signed({ry_r[COORD_W-1], ry_r});
  assign raw[VUX] = $signed({ux_r[COORD_W-1], ux_r}) - $signed({pux_r[COORD_W-1], pux_r});
  assign raw[VUY] = $signed({uy_r[COORD_W-1], uy_r}) - $signed({puy_r[COORD_W-1], puy_r});
  assign raw[VRX] = $signed({rx_r[COORD_W-1], rx_r}) - $signed({prx_r[COORD_W-1], prx_r});
  assign raw[VRY] = $signed({ry_r[COORD_W-1], ry_r}) - $signed({pry_r[COORD_W-1], pry_r});
  assign nz_u = (raw[VUX] != '0) || (raw[VUY] != '0);
  assign nz_r = (raw[VRX] != '0) || (raw[VRY] != '0);

  assign sum_all = sum_r + SUM_W'(prod_r);

  // One restoring square root step: two radicand bits in, one root bit out.
  assign s_sh = {srem_r[SREM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign s_trial = {1'b0, root_r, 2'b01};

  // One restoring division step: one numerator bit in, one quotient bit out.
  assign d_sh = {drem_r[DREM_W-2:0], num_r[NUM_W-1]};
  assign d_den = {1'b0, den_r};
  assign d_ge = (d_sh >= d_den);

  assign sc_u = scale_step(mag_r[VUX], mag_r[VUY]);
  assign sc_r = scale_step(mag_r[VRX], mag_r[VRY]);

  assign dot_mag = dot_r[SUM_W-1] ? SUM_W'(-dot_r) : SUM_W'(dot_r);
  assign t_lim = (qovf_r || quo_r > HALF_Q16) ? HALF_Q16 : quo_r;
  assign sim = dot_r[SUM_W-1] ? (HALF_Q16 - t_lim) : (HALF_Q16 + t_lim);
  assign dir_add = {1'b0, dir_sum_r} + (DIR_W + 1)'(sim);
  assign dist_add = {1'b0, dist_sum_r} + (DIST_W + 1)'(root_r);
  assign loss = {1'b0, quo_r} + (QUO_W + 1)'(drem_r != '0);
  assign score_sum = {1'b0, spat_r} + {1'b0, dirp_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_D_MX: begin
        mul_a = dx;
        mul_b = dx;
      end
      ST_D_MY: begin
        mul_a = dy;
        mul_b = dy;
      end
      ST_U_MX: begin
        mul_a = to_signed(sgn_r[VUX], mag_r[VUX]);
        mul_b = mul_a;
      end
      ST_U_MY: begin
        mul_a = to_signed(sgn_r[VUY], mag_r[VUY]);
        mul_b = mul_a;
      end
      ST_R_MX: begin
        mul_a = to_signed(sgn_r[VRX], mag_r[VRX]);
        mul_b = mul_a;
      end
      ST_R_MY: begin
        mul_a = to_signed(sgn_r[VRY], mag_r[VRY]);
        mul_b = mul_a;
      end
      ST_P_MX: begin
        mul_a = to_signed(sgn_r[VUX], mag_r[VUX]);
        mul_b = to_signed(sgn_r[VRX], mag_r[VRX]);
      end
      ST_P_MY: begin
        mul_a = to_signed(sgn_r[VUY], mag_r[VUY]);
        mul_b = to_signed(sgn_r[VRY], mag_r[VRY]);
      end
      ST_P_LEN: begin
        mul_a = $signed({1'b0, lu_r});
        mul_b = $signed({1'b0, lr_r});
      end
      ST_F_MUL: begin
        mul_a = $signed(DIFF_W'(pt_cnt_r));
        mul_b = $signed({1'b0, (tol_r == '0) ? COORD_W'(1) : tol_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    tol_nxt = tol_r;
    ux_nxt = ux_r;
    uy_nxt = uy_r;
    rx_nxt = rx_r;
    ry_nxt = ry_r;
    last_nxt = last_r;
    pux_nxt = pux_r;
    puy_nxt = puy_r;
    prx_nxt = prx_r;
    pry_nxt = pry_r;
    dist_sum_nxt = dist_sum_r;
    dir_sum_nxt = dir_sum_r;
    vseg_cnt_nxt = vseg_cnt_r;
    pt_cnt_nxt = pt_cnt_r;
    ovf_nxt = ovf_r;
    sgn_nxt = sgn_r;
    mag_nxt = mag_r;
    prod_nxt = prod_r;
    sum_nxt = sum_r;
    dot_nxt = dot_r;
    lu_nxt = lu_r;
    lr_nxt = lr_r;
    rad_nxt = rad_r;
    srem_nxt = srem_r;
    root_nxt = root_r;
    num_nxt = num_r;
    den_nxt = den_r;
    drem_nxt = drem_r;
    quo_nxt = quo_r;
    qovf_nxt = qovf_r;
    it_nxt = it_r;
    spat_nxt = spat_r;
    dirp_nxt = dirp_r;
    out_valid_nxt = out_valid_r;
    out_score_nxt = out_score_r;
    out_spat_nxt = out_spat_r;
    out_dir_nxt = out_dir_r;
    out_tl_nxt = out_tl_r;

    if (cfg_valid) begin
      tol_nxt = cfg_tolerance;
    end
    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ux_nxt = in_user_x;
          uy_nxt = in_user_y;
          rx_nxt = in_ref_x;
          ry_nxt = in_ref_y;
          last_nxt = in_last;
          if (pt_cnt_r >= MAX_CNT) begin
            ovf_nxt = 1'b1;
            state_nxt = in_last ? ST_F_MUL : ST_IDLE;
          end else begin
            state_nxt = ST_D_MX;
          end
        end
      end
      ST_D_MX: begin
        prod_nxt = mul_p;
        state_nxt = ST_D_MY;
      end
      ST_D_MY: begin
        sum_nxt = SUM_W'(prod_r);
        prod_nxt = mul_p;
        state_nxt = ST_D_RT;
      end
      ST_D_RT: begin
        rad_nxt = sum_all[RAD_W-1:0];
        srem_nxt = '0;
        root_nxt = '0;
        it_nxt = SQRT_STEPS;
        ret_nxt = ST_D_ACC;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        rad_nxt = rad_r << 2;
        if (s_sh >= s_trial) begin
          srem_nxt = s_sh - s_trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = s_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        it_nxt = it_r - 1'b1;
        if (it_r == IT_W'(1)) begin
          state_nxt = ret_r;
        end
      end
      ST_D_ACC: begin
        dist_sum_nxt = dist_add[DIST_W] ? DIST_MAX : dist_add[DIST_W-1:0];
        state_nxt = (pt_cnt_r != '0) ? ST_SEG : ST_PT;
      end
      ST_SEG: begin
        for (int i = 0; i < 4; i++) begin
          sgn_nxt[i] = raw[i][DIFF_W-1];
          mag_nxt[i] = raw[i][DIFF_W-1] ? DIFF_W'(-raw[i]) : DIFF_W'(raw[i]);
        end
        state_nxt = (nz_u && nz_r) ? ST_SCALE : ST_PT;
      end
      ST_SCALE: begin
        // Normalize each vector so its larger component lies in [16384, 32767].
        mag_nxt[VUX] = sc_u[2*DIFF_W-1:DIFF_W];
        mag_nxt[VUY] = sc_u[DIFF_W-1:0];
        mag_nxt[VRX] = sc_r[2*DIFF_W-1:DIFF_W];
        mag_nxt[VRY] = sc_r[DIFF_W-1:0];
        if (sc_u[2*DIFF_W] && sc_r[2*DIFF_W]) begin
          state_nxt = ST_U_MX;
        end
      end
      ST_U_MX: begin
        prod_nxt = mul_p;
        state_nxt = ST_U_MY;
      end
      ST_U_MY: begin
        sum_nxt = SUM_W'(prod_r);
        prod_nxt = mul_p;
        state_nxt = ST_U_RT;
      end
      ST_U_RT: begin
        rad_nxt = sum_all[RAD_W-1:0];
        srem_nxt = '0;
        root_nxt = '0;
        it_nxt = SQRT_STEPS;
        ret_nxt = ST_R_MX;
        state_nxt = ST_SQRT;
      end
      ST_R_MX: begin
        lu_nxt = root_r[ROOT_W-2:0];
        prod_nxt = mul_p;
        state_nxt = ST_R_MY;
      end
      ST_R_MY: begin
        sum_nxt = SUM_W'(prod_r);
        prod_nxt = mul_p;
        state_nxt = ST_R_RT;
      end
      ST_R_RT: begin
        rad_nxt = sum_all[RAD_W-1:0];
        srem_nxt = '0;
        root_nxt = '0;
        it_nxt = SQRT_STEPS;
        ret_nxt = ST_P_MX;
        state_nxt = ST_SQRT;
      end
      ST_P_MX: begin
        lr_nxt = root_r[ROOT_W-2:0];
        prod_nxt = mul_p;
        state_nxt = ST_P_MY;
      end
      ST_P_MY: begin
        sum_nxt = SUM_W'(prod_r);
        prod_nxt = mul_p;
        state_nxt = ST_P_LEN;
      end
      ST_P_LEN: begin
        dot_nxt = sum_all;
        prod_nxt = mul_p;
        state_nxt = ST_P_DV;
      end
      ST_P_DV: begin
        num_nxt = {dot_mag[NUM_W-16:0], 15'd0};
        den_nxt = (prod_r == '0) ? DEN_W'(1) : prod_r[DEN_W-1:0];
        drem_nxt = '0;
        quo_nxt = '0;
        qovf_nxt = 1'b0;
        it_nxt = DIV_STEPS;
        ret_nxt = ST_P_ACC;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        num_nxt = num_r << 1;
        drem_nxt = d_ge ? (d_sh - d_den) : d_sh;
        quo_nxt = {quo_r[QUO_W-2:0], d_ge};
        qovf_nxt = qovf_r | quo_r[QUO_W-1];
        it_nxt = it_r - 1'b1;
        if (it_r == IT_W'(1)) begin
          state_nxt = ret_r;
        end
      end
      ST_P_ACC: begin
        dir_sum_nxt = dir_add[DIR_W] ? DIR_MAX : dir_add[DIR_W-1:0];
        vseg_cnt_nxt = vseg_cnt_r + 1'b1;
        state_nxt = ST_PT;
      end
      ST_PT: begin
        pux_nxt = ux_r;
        puy_nxt = uy_r;
        prx_nxt = rx_r;
        pry_nxt = ry_r;
        pt_cnt_nxt = pt_cnt_r + 1'b1;
        state_nxt = last_r ? ST_F_MUL : ST_IDLE;
      end
      ST_F_MUL: begin
        if (pt_cnt_r < CW'(2)) begin
          spat_nxt = '0;
          dirp_nxt = '0;
          state_nxt = ST_EMIT;
        end else begin
          prod_nxt = mul_p;
          state_nxt = ST_F_DV;
        end
      end
      ST_F_DV: begin
        num_nxt = NUM_W'({dist_sum_r, 16'd0});
        den_nxt = prod_r[DEN_W-1:0];
        drem_nxt = '0;
        quo_nxt = '0;
        qovf_nxt = 1'b0;
        it_nxt = DIV_STEPS;
        ret_nxt = ST_F_SP;
        state_nxt = ST_DIV;
      end
      ST_F_SP: begin
        // The loss is rounded up, so the spatial part is rounded down.
        if (qovf_r || loss >= {1'b0, ONE_Q16}) begin
          spat_nxt = '0;
        end else begin
          spat_nxt = ONE_Q16 - loss[SCORE_W-1:0];
        end
        if (vseg_cnt_r == '0) begin
          dirp_nxt = ONE_Q16;
          state_nxt = ST_EMIT;
        end else begin
          num_nxt = NUM_W'(dir_sum_r);
          den_nxt = DEN_W'(vseg_cnt_r);
          drem_nxt = '0;
          quo_nxt = '0;
          qovf_nxt = 1'b0;
          it_nxt = DIV_STEPS;
          ret_nxt = ST_F_DIR;
          state_nxt = ST_DIV;
        end
      end
      ST_F_DIR: begin
        dirp_nxt = (qovf_r || quo_r > ONE_Q16) ? ONE_Q16 : quo_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_score_nxt = score_sum[SCORE_W:1];
          out_spat_nxt = spat_r;
          out_dir_nxt = dirp_r;
          out_tl_nxt = ovf_r;
          pux_nxt = '0;
          puy_nxt = '0;
          prx_nxt = '0;
          pry_nxt = '0;
          dist_sum_nxt = '0;
          dir_sum_nxt = '0;
          vseg_cnt_nxt = '0;
          pt_cnt_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r <= ST_IDLE;
      tol_r <= TOL_RESET;
      pux_r <= '0;
      puy_r <= '0;
      prx_r <= '0;
      pry_r <= '0;
      dist_sum_r <= '0;
      dir_sum_r <= '0;
      vseg_cnt_r <= '0;
      pt_cnt_r <= '0;
      ovf_r <= 1'b0;
      it_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      tol_r <= tol_nxt;
      pux_r <= pux_nxt;
      puy_r <= puy_nxt;
      prx_r <= prx_nxt;
      pry_r <= pry_nxt;
      dist_sum_r <= dist_sum_nxt;
      dir_sum_r <= dir_sum_nxt;
      vseg_cnt_r <= vseg_cnt_nxt;
      pt_cnt_r <= pt_cnt_nxt;
      ovf_r <= ovf_nxt;
      it_r <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ux_r <= ux_nxt;
    uy_r <= uy_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    last_r <= last_nxt;
    sgn_r <= sgn_nxt;
    mag_r <= mag_nxt;
    prod_r <= prod_nxt;
    sum_r <= sum_nxt;
    dot_r <= dot_nxt;
    lu_r <= lu_nxt;
    lr_r <= lr_nxt;
    rad_r <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    drem_r <= drem_nxt;
    quo_r <= quo_nxt;
    qovf_r <= qovf_nxt;
    spat_r <= spat_nxt;
    dirp_r <= dirp_nxt;
    out_score_r <= out_score_nxt;
    out_spat_r <= out_spat_nxt;
    out_dir_r <= out_dir_nxt;
    out_tl_r <= out_tl_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_score = out_score_r;
  assign out_spatial_part = out_spat_r;
  assign out_direction_part = out_dir_r;
  assign out_too_long = out_tl_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pt_cnt_r <= MAX_CNT)
    else $error("point count exceeds the maximum");

  a_seg_le_pts: assert property (@(posedge clk) disable iff (!rst_n)
    vseg_cnt_r <= pt_cnt_r)
    else $error("more valid segments than points");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && pt_cnt_r == '0 && dist_sum_r == '0 && !ovf_r))
    else $error("result transaction did not clear the accumulators");
`endif

endmodule
